// ===== rtl/core/lgbcm_pkg.sv =====
// shared types, constants and helpers for the lehmer generator bit change monitor
`timescale 1ns / 1ps
`default_nettype none

package lgbcm_pkg;

   // parameter defaults
   localparam int VALUE_WIDTH_DEF = 64;
   localparam int COUNT_WIDTH_DEF = 32;

   // fixed field widths of the channels
   localparam int KIND_WIDTH        = 1;
   localparam int BIN_SELECT_WIDTH  = 7;
   localparam int STEP_COUNT_WIDTH  = 32;
   localparam int VALUE_OUT_WIDTH   = 64;
   localparam int CHANGES_WIDTH     = 7;
   localparam int BIN_COUNT_WIDTH   = 32;
   localparam int CHANGE_SUM_WIDTH  = 38;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS    = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MULTIPLIER = 1'b1;
   localparam logic [CSR_DATA_WIDTH-1:0] MODULUS_RESET    = 64'd13166748625691186689;
   localparam logic [CSR_DATA_WIDTH-1:0] MULTIPLIER_RESET = 64'd3180491373;

   // request kinds
   localparam logic [KIND_WIDTH-1:0] KIND_STEP = 1'b0;
   localparam logic [KIND_WIDTH-1:0] KIND_READ = 1'b1;

   // popcount digit
   localparam int POP_DIGIT     = 4;
   localparam int POP_SUM_WIDTH = $clog2(POP_DIGIT + 1);

   typedef struct packed {
      logic [KIND_WIDTH-1:0]       kind;
      logic [BIN_SELECT_WIDTH-1:0] bin_select;
   } req_type;

   typedef struct packed {
      logic [STEP_COUNT_WIDTH-1:0] step_count;
      logic [VALUE_OUT_WIDTH-1:0]  current_value;
      logic [CHANGES_WIDTH-1:0]    changed_bits;
      logic [BIN_COUNT_WIDTH-1:0]  bin_count;
      logic [CHANGES_WIDTH-1:0]    fewest_changes;
      logic [CHANGES_WIDTH-1:0]    most_changes;
      logic [CHANGE_SUM_WIDTH-1:0] change_total;
      logic [VALUE_OUT_WIDTH-1:0]  fewest_new_value;
      logic [VALUE_OUT_WIDTH-1:0]  fewest_old_value;
      logic [VALUE_OUT_WIDTH-1:0]  most_new_value;
      logic [VALUE_OUT_WIDTH-1:0]  most_old_value;
   } rsp_type;

   typedef struct packed {
      logic lookup;
      logic bump;
      logic report;
   } stats_cmd_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_REDUCE,
      MUL_LOOP
   } mul_state_type;

   typedef enum logic [2:0] {
      TOP_IDLE,
      TOP_MUL,
      TOP_POP,
      TOP_LOOKUP,
      TOP_APPLY,
      TOP_SEND
   } top_state_type;

   function automatic logic [POP_SUM_WIDTH-1:0] digit_ones(input logic [POP_DIGIT-1:0] digit);
      logic [POP_SUM_WIDTH-1:0] ones;
      ones = '0;
      for (int i = 0; i < POP_DIGIT; i++) begin
         ones = ones + POP_SUM_WIDTH'(digit[i]);
      end
      return ones;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lgbcm_modmul.sv =====
// bit-serial modular multiplier with serial pre-reduction of the base
`timescale 1ns / 1ps
`default_nettype none

module lgbcm_modmul #(
   parameter int VALUE_WIDTH = lgbcm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] base_value,
   input  logic [VALUE_WIDTH-1:0] factor,
   input  logic [VALUE_WIDTH-1:0] modulus,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] product
);

   localparam int W    = VALUE_WIDTH;
   localparam int CntW = $clog2(W + 1);

   lgbcm_pkg::mul_state_type state_ff, state_in;
   logic [W-1:0]    acc_ff, acc_in;
   logic [W-1:0]    base_ff, base_in;
   logic [W-1:0]    bits_ff, bits_in;
   logic [W-1:0]    factor_ff, factor_in;
   logic [W-1:0]    mod_ff, mod_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            done_ff, done_in;

   logic [W:0]   red_sum, red_diff;
   logic [W+1:0] mul_sum, mul_m1, mul_m2, mod_x1, mod_x2;

   always_comb begin
      red_sum  = {acc_ff, bits_ff[W-1]};
      red_diff = red_sum - {1'b0, mod_ff};
      mod_x1   = {2'b00, mod_ff};
      mod_x2   = {1'b0, mod_ff, 1'b0};
      mul_sum  = {1'b0, acc_ff, 1'b0} + (bits_ff[W-1] ? {2'b00, base_ff} : '0);
      mul_m1   = mul_sum - mod_x1;
      mul_m2   = mul_sum - mod_x2;

      state_in  = state_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      bits_in   = bits_ff;
      factor_in = factor_ff;
      mod_in    = mod_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;

      unique case (state_ff)
         lgbcm_pkg::MUL_IDLE: begin
            if (start) begin
               mod_in    = modulus;
               factor_in = factor;
               acc_in    = '0;
               cnt_in    = CntW'(W);
               if ((modulus != '0) && (base_value >= modulus)) begin
                  bits_in  = base_value;
                  state_in = lgbcm_pkg::MUL_REDUCE;
               end else begin
                  base_in  = base_value;
                  bits_in  = factor;
                  state_in = lgbcm_pkg::MUL_LOOP;
               end
            end
         end
         lgbcm_pkg::MUL_REDUCE: begin
            // restoring remainder, one base bit per cycle
            if (red_sum >= {1'b0, mod_ff}) begin
               acc_in = red_diff[W-1:0];
            end else begin
               acc_in = red_sum[W-1:0];
            end
            bits_in = bits_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               base_in  = acc_in;
               acc_in   = '0;
               bits_in  = factor_ff;
               cnt_in   = CntW'(W);
               state_in = lgbcm_pkg::MUL_LOOP;
            end
         end
         lgbcm_pkg::MUL_LOOP: begin
            // double and add, one factor bit per cycle
            if (mod_ff == '0) begin
               acc_in = mul_sum[W-1:0];
            end else if (mul_sum >= mod_x2) begin
               acc_in = mul_m2[W-1:0];
            end else if (mul_sum >= mod_x1) begin
               acc_in = mul_m1[W-1:0];
            end else begin
               acc_in = mul_sum[W-1:0];
            end
            bits_in = bits_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               done_in  = 1'b1;
               state_in = lgbcm_pkg::MUL_IDLE;
            end
         end
         default: begin
            state_in = lgbcm_pkg::MUL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lgbcm_pkg::MUL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      bits_ff   <= bits_in;
      factor_ff <= factor_in;
      mod_ff    <= mod_in;
      cnt_ff    <= cnt_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lgbcm_popcnt.sv =====
// digit-serial population count of a state difference
`timescale 1ns / 1ps
`default_nettype none

module lgbcm_popcnt #(
   parameter int VALUE_WIDTH = lgbcm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [VALUE_WIDTH-1:0]         value,
   output logic                           done,
   output logic [$clog2(VALUE_WIDTH+1)-1:0] ones
);

   localparam int W        = VALUE_WIDTH;
   localparam int ChgW     = $clog2(W + 1);
   localparam int PopDigit = lgbcm_pkg::POP_DIGIT;
   localparam int Digits   = (W + PopDigit - 1) / PopDigit;
   localparam int LeftW    = $clog2(Digits + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [W-1:0]     shift_ff, shift_in;
   logic [ChgW-1:0]  sum_ff, sum_in;
   logic [LeftW-1:0] left_ff, left_in;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      shift_in = shift_ff;
      sum_in   = sum_ff;
      left_in  = left_ff;
      if (start) begin
         busy_in  = 1'b1;
         shift_in = value;
         sum_in   = '0;
         left_in  = LeftW'(Digits);
      end else if (busy_ff) begin
         sum_in   = sum_ff + ChgW'(lgbcm_pkg::digit_ones(shift_ff[PopDigit-1:0]));
         shift_in = {{PopDigit{1'b0}}, shift_ff[W-1:PopDigit]};
         left_in  = left_ff - 1'b1;
         if (left_ff == LeftW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      sum_ff   <= sum_in;
      left_ff  <= left_in;
   end

   assign done = done_ff;
   assign ones = sum_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lgbcm_stats.sv =====
// change histogram memory and running step statistics
`timescale 1ns / 1ps
`default_nettype none

module lgbcm_stats #(
   parameter int VALUE_WIDTH = lgbcm_pkg::VALUE_WIDTH_DEF,
   parameter int COUNT_WIDTH = lgbcm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lgbcm_pkg::stats_cmd_type                cmd,
   input  logic [lgbcm_pkg::BIN_SELECT_WIDTH-1:0]  bin,
   input  logic [VALUE_WIDTH-1:0]                  new_value,
   input  logic [VALUE_WIDTH-1:0]                  old_value,
   output logic [COUNT_WIDTH-1:0]                  bin_count,
   output logic [COUNT_WIDTH-1:0]                  step_count,
   output logic [COUNT_WIDTH+5:0]                  change_sum,
   output logic [$clog2(VALUE_WIDTH+1)-1:0]        low_mark,
   output logic [$clog2(VALUE_WIDTH+1)-1:0]        high_mark,
   output logic [VALUE_WIDTH-1:0]                  low_new,
   output logic [VALUE_WIDTH-1:0]                  low_old,
   output logic [VALUE_WIDTH-1:0]                  high_new,
   output logic [VALUE_WIDTH-1:0]                  high_old
);

   localparam int W    = VALUE_WIDTH;
   localparam int CW   = COUNT_WIDTH;
   localparam int SumW = COUNT_WIDTH + 6;
   localparam int IdxW = $clog2(W + 1);
   localparam int BinW = lgbcm_pkg::BIN_SELECT_WIDTH;

   logic [CW-1:0] hist_mem [0:W];
   logic [W:0]    valid_ff;

   logic [CW-1:0]   rd_data_ff;
   logic            hit_ff;
   logic [IdxW-1:0] idx_ff;
   logic [CW-1:0]   bin_count_ff;
   logic [CW-1:0]   steps_ff;
   logic [SumW-1:0] sum_ff;
   logic [IdxW-1:0] low_ff, high_ff;
   logic [W-1:0]    low_new_ff, low_old_ff, high_new_ff, high_old_ff;

   logic [IdxW-1:0] bin_idx;
   logic            in_range;
   logic [CW-1:0]   cur_count, bumped;
   logic [SumW:0]   sum_ext;

   always_comb begin
      bin_idx   = bin[IdxW-1:0];
      in_range  = (bin <= BinW'(W));
      cur_count = hit_ff ? rd_data_ff : '0;
      bumped    = (cur_count == '1) ? cur_count : cur_count + 1'b1;
      sum_ext   = {1'b0, sum_ff} + (SumW + 1)'(idx_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         rd_data_ff <= hist_mem[bin_idx];
      end
      if (cmd.bump) begin
         hist_mem[idx_ff] <= bumped;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         idx_ff <= bin_idx;
      end
      if (cmd.bump) begin
         bin_count_ff <= bumped;
      end else if (cmd.report) begin
         bin_count_ff <= cur_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         hit_ff      <= 1'b0;
         steps_ff    <= '0;
         sum_ff      <= '0;
         low_ff      <= IdxW'(W);
         high_ff     <= '0;
         low_new_ff  <= '0;
         low_old_ff  <= '0;
         high_new_ff <= '0;
         high_old_ff <= '0;
      end else begin
         if (cmd.lookup) begin
            hit_ff <= in_range && valid_ff[bin_idx];
         end
         if (cmd.bump) begin
            valid_ff[idx_ff] <= 1'b1;
            if (steps_ff != '1) begin
               steps_ff <= steps_ff + 1'b1;
            end
            sum_ff <= sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
            if (idx_ff < low_ff) begin
               low_ff     <= idx_ff;
               low_new_ff <= new_value;
               low_old_ff <= old_value;
            end
            if (idx_ff > high_ff) begin
               high_ff     <= idx_ff;
               high_new_ff <= new_value;
               high_old_ff <= old_value;
            end
         end
      end
   end

   assign bin_count  = bin_count_ff;
   assign step_count = steps_ff;
   assign change_sum = sum_ff;
   assign low_mark   = low_ff;
   assign high_mark  = high_ff;
   assign low_new    = low_new_ff;
   assign low_old    = low_old_ff;
   assign high_new   = high_new_ff;
   assign high_old   = high_old_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lehmer_generator_bit_change_monitor.sv =====
// top level of the lehmer generator bit change monitor
// A step request multiplies the generator state by the multiplier modulo the
// modulus (zero modulus wraps at VALUE_WIDTH bits), counts the bits changed
// against the previous state, bumps that count's histogram bin and updates the
// running statistics; a read request returns one bin's count. One request is
// in work at a time, and the next one is taken while the previous response
// waits in the output register. A step runs through the bit-serial modular
// multiplier (one multiplier bit per cycle) and the 4-bit digit popcount; when
// the state is not below the modulus (after a modulus write, or a modulus of
// one) a serial reduction of the state runs before the multiply. A read
// request goes straight to the histogram lookup, apply and send states.
// The histogram needs no clearing pass: each bin has a valid bit cleared by reset.
`timescale 1ns / 1ps
`default_nettype none

module lehmer_generator_bit_change_monitor #(
   parameter int VALUE_WIDTH = lgbcm_pkg::VALUE_WIDTH_DEF,
   parameter int COUNT_WIDTH = lgbcm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  lgbcm_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output lgbcm_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_write,
   input  logic [lgbcm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lgbcm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int W       = VALUE_WIDTH;
   localparam int CW      = COUNT_WIDTH;
   localparam int ChgW    = $clog2(W + 1);
   localparam int BinW    = lgbcm_pkg::BIN_SELECT_WIDTH;
   localparam int StepW   = lgbcm_pkg::STEP_COUNT_WIDTH;
   localparam int ValOutW = lgbcm_pkg::VALUE_OUT_WIDTH;
   localparam int ChOutW  = lgbcm_pkg::CHANGES_WIDTH;
   localparam int BinCntW = lgbcm_pkg::BIN_COUNT_WIDTH;
   localparam int SumOutW = lgbcm_pkg::CHANGE_SUM_WIDTH;

   lgbcm_pkg::top_state_type state_ff, state_in;
   logic [W-1:0]    modulus_ff, multiplier_ff;
   logic [W-1:0]    gen_value_ff, prior_value_ff;
   logic [W-1:0]    next_ff, next_in;
   logic            kind_ff, kind_in;
   logic [BinW-1:0] bin_ff, bin_in;
   logic            rsp_valid_ff, rsp_valid_in;
   lgbcm_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic            advance;

   logic                accept;
   logic                mul_start, mul_done;
   logic [W-1:0]        mul_product;
   logic                pop_start, pop_done;
   logic [ChgW-1:0]     pop_ones;
   lgbcm_pkg::stats_cmd_type stats_cmd;

   logic [CW-1:0]   st_bin_count, st_steps;
   logic [CW+5:0]   st_sum;
   logic [ChgW-1:0] st_low, st_high;
   logic [W-1:0]    st_low_new, st_low_old, st_high_new, st_high_old;

   lgbcm_modmul #(
      .VALUE_WIDTH(W)
   ) u_modmul (
      .clock      (clock),
      .reset      (reset),
      .start      (mul_start),
      .base_value (gen_value_ff),
      .factor     (multiplier_ff),
      .modulus    (modulus_ff),
      .done       (mul_done),
      .product    (mul_product)
   );

   lgbcm_popcnt #(
      .VALUE_WIDTH(W)
   ) u_popcnt (
      .clock (clock),
      .reset (reset),
      .start (pop_start),
      .value (mul_product ^ prior_value_ff),
      .done  (pop_done),
      .ones  (pop_ones)
   );

   lgbcm_stats #(
      .VALUE_WIDTH(W),
      .COUNT_WIDTH(CW)
   ) u_stats (
      .clock      (clock),
      .reset      (reset),
      .cmd        (stats_cmd),
      .bin        (bin_ff),
      .new_value  (next_ff),
      .old_value  (prior_value_ff),
      .bin_count  (st_bin_count),
      .step_count (st_steps),
      .change_sum (st_sum),
      .low_mark   (st_low),
      .high_mark  (st_high),
      .low_new    (st_low_new),
      .low_old    (st_low_old),
      .high_new   (st_high_new),
      .high_old   (st_high_old)
   );

   assign req_stall = (state_ff != lgbcm_pkg::TOP_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      next_in      = next_ff;
      kind_in      = kind_ff;
      bin_in       = bin_ff;
      mul_start    = 1'b0;
      pop_start    = 1'b0;
      stats_cmd    = '0;
      advance      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         lgbcm_pkg::TOP_IDLE: begin
            if (accept) begin
               kind_in = req_data.kind;
               bin_in  = req_data.bin_select;
               if (req_data.kind == lgbcm_pkg::KIND_STEP) begin
                  mul_start = 1'b1;
                  state_in  = lgbcm_pkg::TOP_MUL;
               end else begin
                  state_in = lgbcm_pkg::TOP_LOOKUP;
               end
            end
         end
         lgbcm_pkg::TOP_MUL: begin
            if (mul_done) begin
               next_in   = mul_product;
               pop_start = 1'b1;
               state_in  = lgbcm_pkg::TOP_POP;
            end
         end
         lgbcm_pkg::TOP_POP: begin
            if (pop_done) begin
               bin_in   = BinW'(pop_ones);
               state_in = lgbcm_pkg::TOP_LOOKUP;
            end
         end
         lgbcm_pkg::TOP_LOOKUP: begin
            stats_cmd.lookup = 1'b1;
            state_in         = lgbcm_pkg::TOP_APPLY;
         end
         lgbcm_pkg::TOP_APPLY: begin
            if (kind_ff == lgbcm_pkg::KIND_STEP) begin
               stats_cmd.bump = 1'b1;
               advance        = 1'b1;
            end else begin
               stats_cmd.report = 1'b1;
            end
            state_in = lgbcm_pkg::TOP_SEND;
         end
         lgbcm_pkg::TOP_SEND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.step_count       = StepW'(st_steps);
               rsp_data_in.current_value    = ValOutW'(gen_value_ff);
               rsp_data_in.changed_bits     = (kind_ff == lgbcm_pkg::KIND_STEP) ?
                                              ChOutW'(bin_ff) : '0;
               rsp_data_in.bin_count        = BinCntW'(st_bin_count);
               rsp_data_in.fewest_changes   = ChOutW'(st_low);
               rsp_data_in.most_changes     = ChOutW'(st_high);
               rsp_data_in.change_total     = SumOutW'(st_sum);
               rsp_data_in.fewest_new_value = ValOutW'(st_low_new);
               rsp_data_in.fewest_old_value = ValOutW'(st_low_old);
               rsp_data_in.most_new_value   = ValOutW'(st_high_new);
               rsp_data_in.most_old_value   = ValOutW'(st_high_old);
               state_in                     = lgbcm_pkg::TOP_IDLE;
            end
         end
         default: begin
            state_in = lgbcm_pkg::TOP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lgbcm_pkg::TOP_IDLE;
         rsp_valid_ff   <= 1'b0;
         modulus_ff     <= W'(lgbcm_pkg::MODULUS_RESET);
         multiplier_ff  <= W'(lgbcm_pkg::MULTIPLIER_RESET);
         gen_value_ff   <= W'(1);
         prior_value_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               lgbcm_pkg::CSR_MODULUS:    modulus_ff    <= csr_wdata[W-1:0];
               lgbcm_pkg::CSR_MULTIPLIER: multiplier_ff <= csr_wdata[W-1:0];
               default: ;
            endcase
         end
         if (advance) begin
            gen_value_ff   <= next_ff;
            prior_value_ff <= next_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      next_ff     <= next_in;
      kind_ff     <= kind_in;
      bin_ff      <= bin_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench for the lehmer generator bit change monitor
`timescale 1ns / 1ps

module tb;

   typedef enum logic [1:0] {
      ROW_REQUEST,
      ROW_MODULUS,
      ROW_MULTIPLIER
   } plan_op_type;

   typedef struct packed {
      plan_op_type        op;
      logic [63:0]        value;
      lgbcm_pkg::req_type req;
      logic               reset_view;
   } plan_row_type;

   localparam int RANDOM_REQUESTS = 860;
   localparam int CLOSING_REQUESTS = 25;
   localparam int HOLD_CYCLES = 600;
   localparam int HOLD_AT = 30;
   localparam logic [lgbcm_pkg::CHANGE_SUM_WIDTH-1:0] CHANGE_SUM_MAX = '1;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] MINUS_ONE_MOD_MAX = 64'hFFFF_FFFF_FFFF_FFFE;

   localparam lgbcm_pkg::rsp_type RESET_VIEW = '{
      step_count: 32'd0, current_value: 64'd1, changed_bits: 7'd0, bin_count: 32'd0,
      fewest_changes: 7'd64, most_changes: 7'd0, change_total: 38'd0,
      fewest_new_value: 64'd0, fewest_old_value: 64'd0,
      most_new_value: 64'd0, most_old_value: 64'd0
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   lgbcm_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   lgbcm_pkg::rsp_type rsp_data;
   logic               csr_write;
   logic [lgbcm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [lgbcm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   lehmer_generator_bit_change_monitor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // generator model
   logic [63:0] cfg_modulus = lgbcm_pkg::MODULUS_RESET;
   logic [63:0] cfg_multiplier = lgbcm_pkg::MULTIPLIER_RESET;
   logic [63:0] lcg_state = 64'd1;
   logic [63:0] last_state = 64'd0;
   logic [31:0] change_bins [0:64];
   logic [31:0] step_total = '0;
   logic [lgbcm_pkg::CHANGE_SUM_WIDTH-1:0] change_accum = '0;
   logic [6:0]  fewest_mark = 7'd64;
   logic [6:0]  most_mark = 7'd0;
   logic [63:0] fewest_pair_new = '0;
   logic [63:0] fewest_pair_old = '0;
   logic [63:0] most_pair_new = '0;
   logic [63:0] most_pair_old = '0;

   lgbcm_pkg::rsp_type pending_responses [$];
   plan_row_type       plan_table [$];
   int                 mismatches = 0;
   bit                 hold_off_pending = 0;
   bit                 sender_calm = 0;
   bit                 receiver_calm = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [63:0] lehmer_next(logic [63:0] s, logic [63:0] g, logic [63:0] m);
      logic [127:0] prod;
      if (m == '0) return s * g;
      prod = {64'd0, s % m} * {64'd0, g % m};
      return 64'(prod % {64'd0, m});
   endfunction

   function automatic lgbcm_pkg::rsp_type advance_generator(lgbcm_pkg::req_type r);
      lgbcm_pkg::rsp_type o;
      logic [63:0] nxt;
      logic [63:0] diff;
      logic [6:0]  flips;
      logic [31:0] hits;
      flips = '0;
      hits = '0;
      if (r.kind == lgbcm_pkg::KIND_STEP) begin
         nxt = lehmer_next(lcg_state, cfg_multiplier, cfg_modulus);
         diff = nxt ^ last_state;
         for (int i = 0; i < 64; i++) flips = flips + 7'(diff[i]);
         if (change_bins[flips] != '1) change_bins[flips] = change_bins[flips] + 1;
         hits = change_bins[flips];
         if (flips < fewest_mark) begin
            fewest_mark = flips;
            fewest_pair_new = nxt;
            fewest_pair_old = last_state;
         end
         if (flips > most_mark) begin
            most_mark = flips;
            most_pair_new = nxt;
            most_pair_old = last_state;
         end
         if (CHANGE_SUM_MAX - change_accum >= lgbcm_pkg::CHANGE_SUM_WIDTH'(flips)) begin
            change_accum = change_accum + lgbcm_pkg::CHANGE_SUM_WIDTH'(flips);
         end else begin
            change_accum = CHANGE_SUM_MAX;
         end
         if (step_total != '1) step_total = step_total + 1;
         lcg_state = nxt;
         last_state = nxt;
      end else if (r.bin_select <= 7'd64) begin
         hits = change_bins[r.bin_select];
      end
      o.step_count = step_total;
      o.current_value = lcg_state;
      o.changed_bits = flips;
      o.bin_count = hits;
      o.fewest_changes = fewest_mark;
      o.most_changes = most_mark;
      o.change_total = change_accum;
      o.fewest_new_value = fewest_pair_new;
      o.fewest_old_value = fewest_pair_old;
      o.most_new_value = most_pair_new;
      o.most_old_value = most_pair_old;
      return o;
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] prime_at(int i);
      case (i)
         0: return 64'd2;
         1: return 64'd13;
         2: return 64'd251;
         3: return 64'd65521;
         4: return 64'd2147483647;
         5: return 64'd2305843009213693951;
         6: return 64'd18446744073709551557;
         default: return lgbcm_pkg::MODULUS_RESET;
      endcase
   endfunction

   function automatic lgbcm_pkg::req_type random_request();
      lgbcm_pkg::req_type r;
      int                 pick;
      r.kind = ($urandom_range(0, 9) < 7) ? lgbcm_pkg::KIND_STEP : lgbcm_pkg::KIND_READ;
      pick = $urandom_range(0, 9);
      if (pick < 5) r.bin_select = 7'($urandom_range(20, 44));
      else if (pick < 8) r.bin_select = 7'($urandom_range(0, 64));
      else r.bin_select = 7'($urandom_range(0, 127));
      return r;
   endfunction

   task automatic flag_mismatch(string line);
      $display("%t mismatch: %s", $realtime, line);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   task automatic add_row(plan_op_type op, logic [63:0] value,
                          logic [lgbcm_pkg::KIND_WIDTH-1:0] kind,
                          logic [lgbcm_pkg::BIN_SELECT_WIDTH-1:0] bin, logic reset_view);
      plan_row_type row;
      row.op = op;
      row.value = value;
      row.req.kind = kind;
      row.req.bin_select = bin;
      row.reset_view = reset_view;
      plan_table = {plan_table, row};
   endtask

   task automatic send_request(lgbcm_pkg::req_type r, int gap, logic reset_view);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      if (reset_view) pending_responses = {pending_responses, RESET_VIEW};
      else pending_responses = {pending_responses, advance_generator(r)};
   endtask

   task automatic drain_all();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(logic [lgbcm_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                 logic [63:0] value);
      drain_all();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == lgbcm_pkg::CSR_MODULUS) cfg_modulus = value;
      else cfg_multiplier = value;
   endtask

   // keeps the generator state away from zero, which no setting can leave
   task automatic choose_setting();
      logic [63:0] m;
      logic [63:0] g;
      int          pick;
      pick = $urandom_range(0, 3);
      if (pick == 1 && lcg_state == ALL_ONES) pick = 0;
      case (pick)
         0: begin
            m = '0;
            g = {$urandom, $urandom} | 64'd1;
         end
         1: begin
            m = ALL_ONES;
            if ($urandom_range(0, 3) == 0) g = MINUS_ONE_MOD_MAX;
            else g = 64'd1 << $urandom_range(1, 63);
         end
         default: begin
            do m = prime_at($urandom_range(0, 7)); while (lcg_state % m == 0);
            if ($urandom_range(0, 3) == 0) begin
               g = 64'd1;
            end else begin
               do g = {$urandom, $urandom}; while (g % m == 0);
            end
         end
      endcase
      write_register(lgbcm_pkg::CSR_MODULUS, m);
      write_register(lgbcm_pkg::CSR_MULTIPLIER, g);
   endtask

   always @(posedge clock) begin : check_responses
      lgbcm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            flag_mismatch("response with no request pending");
         end else begin
            want = pending_responses.pop_front();
            check_field("step_count", 64'(rsp_data.step_count), 64'(want.step_count));
            check_field("current_value", rsp_data.current_value, want.current_value);
            check_field("changed_bits", 64'(rsp_data.changed_bits), 64'(want.changed_bits));
            check_field("bin_count", 64'(rsp_data.bin_count), 64'(want.bin_count));
            check_field("fewest_changes", 64'(rsp_data.fewest_changes),
                        64'(want.fewest_changes));
            check_field("most_changes", 64'(rsp_data.most_changes), 64'(want.most_changes));
            check_field("change_total", 64'(rsp_data.change_total), 64'(want.change_total));
            check_field("fewest_new_value", rsp_data.fewest_new_value, want.fewest_new_value);
            check_field("fewest_old_value", rsp_data.fewest_old_value, want.fewest_old_value);
            check_field("most_new_value", rsp_data.most_new_value, want.most_new_value);
            check_field("most_old_value", rsp_data.most_old_value, want.most_old_value);
         end
      end
   end

   // response side back-pressure, with one long hold-off on request
   initial begin : drive_rsp_stall
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            stall_left = HOLD_CYCLES;
            hold_off_pending = 0;
         end else if (stall_left == 0 && !receiver_calm && $urandom_range(0, 3) == 0) begin
            stall_left = idle_gap();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int sent;
      int phase_len;
      int gap;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = lgbcm_pkg::CSR_MODULUS;
      csr_wdata = '0;
      reset = 1'b1;
      for (int i = 0; i <= 64; i++) change_bins[i] = '0;

      // reads straight after reset
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_READ, 7'd0, 1'b1);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_READ, 7'd64, 1'b1);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_READ, 7'd127, 1'b1);
      // first step compares against a zero previous state
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      // unit multiplier leaves the state alone
      add_row(ROW_MULTIPLIER, 64'd1, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_READ, 7'd0, 1'b0);
      // state and multiplier both above a small prime
      add_row(ROW_MODULUS, 64'd2147483647, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_MULTIPLIER, ALL_ONES, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_READ, 7'd65, 1'b0);
      // zero modulus wraps the product
      add_row(ROW_MODULUS, 64'd0, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_READ, 7'd63, 1'b0);
      // all-ones modulus with minus one flips every bit
      add_row(ROW_MODULUS, ALL_ONES, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_MULTIPLIER, MINUS_ONE_MOD_MAX, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_READ, 7'd64, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_READ, 7'd0, 1'b0);
      add_row(ROW_MODULUS, lgbcm_pkg::MODULUS_RESET, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_MULTIPLIER, lgbcm_pkg::MULTIPLIER_RESET, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_STEP, 7'd0, 1'b0);
      add_row(ROW_REQUEST, '0, lgbcm_pkg::KIND_READ, 7'd100, 1'b0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan_table[i]) begin
         case (plan_table[i].op)
            ROW_MODULUS: write_register(lgbcm_pkg::CSR_MODULUS, plan_table[i].value);
            ROW_MULTIPLIER: write_register(lgbcm_pkg::CSR_MULTIPLIER, plan_table[i].value);
            default: send_request(plan_table[i].req, idle_gap(), plan_table[i].reset_view);
         endcase
      end

      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         choose_setting();
         sender_calm = ($urandom_range(0, 3) == 0);
         receiver_calm = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(40, 140);
         for (int k = 0; k < phase_len && sent < RANDOM_REQUESTS; k++) begin
            if (sent == HOLD_AT) hold_off_pending = 1;
            if (sender_calm || (sent >= HOLD_AT && sent < HOLD_AT + 20)) gap = 0;
            else gap = idle_gap();
            send_request(random_request(), gap, 1'b0);
            sent++;
            if ($urandom_range(0, 199) == 0) drain_all();
         end
      end

      // modulus one collapses the state to zero for good, so it comes last
      write_register(lgbcm_pkg::CSR_MODULUS, 64'd1);
      receiver_calm = 0;
      for (int k = 0; k < CLOSING_REQUESTS; k++) begin
         send_request(random_request(), idle_gap(), 1'b0);
      end

      drain_all();
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/lgbcm_pkg.sv
rtl/core/lgbcm_modmul.sv
rtl/core/lgbcm_popcnt.sv
rtl/core/lgbcm_stats.sv
rtl/core/lehmer_generator_bit_change_monitor.sv
tb/sv/tb.sv
